>>> src/psc_pkg.sv
// Shared types and constants for the pressure sensor compensation block.
// No dependencies; every other file refers to this package by scoped names.
package psc_pkg;

	localparam int RawShift  = 6;
	localparam int RawWidth  = 16;
	localparam int CountW    = RawWidth - RawShift;
	localparam int CoefW     = 16;
	localparam int CfgIdxW   = 3;
	localparam int CompW     = 15;
	localparam int DivShift  = 13;

	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	// Calibration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_A0  = 3'd0,
		REG_B1  = 3'd1,
		REG_B2  = 3'd2,
		REG_C12 = 3'd3,
		REG_C11 = 3'd4,
		REG_C22 = 3'd5
	} coef_reg_t;

	typedef logic signed [CoefW-1:0] coef_t;

	typedef struct packed {
		coef_t a0;
		coef_t b1;
		coef_t b2;
		coef_t c12;
		coef_t c11;
		coef_t c22;
	} coefs_t;

endpackage

>>> src/psc_ifs.sv
// Valid/ready channel interfaces for samples, results and calibration writes.
// Depends on psc_pkg for field widths.
interface psc_sample_if;
	logic                            valid;
	logic                            ready;
	logic [psc_pkg::RawWidth-1:0]    pressure_raw;
	logic [psc_pkg::RawWidth-1:0]    temperature_raw;

	modport source (output valid, output pressure_raw, output temperature_raw, input ready);
	modport sink (input valid, input pressure_raw, input temperature_raw, output ready);
endinterface

interface psc_result_if;
	logic                            valid;
	logic                            ready;
	logic signed [psc_pkg::CompW-1:0] pressure_comp;

	modport source (output valid, output pressure_comp, input ready);
	modport sink (input valid, input pressure_comp, output ready);
endinterface

interface psc_cfg_if;
	logic                        valid;
	logic                        ready;
	psc_pkg::cfg_idx_t           index;
	logic [psc_pkg::CoefW-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/pressure_sensor_compensation.sv
// Top level: six-stage pipeline evaluating the pressure compensation polynomial.
// Depends on psc_pkg, psc_ifs and psc_coef_regs.
//
// Usage:
//   sample  - sink channel, one raw pressure/temperature pair per item. The top
//             ten bits of each 16-bit word are the counts; the low six are ignored.
//   result  - source channel, one compensated pressure count per item.
//   cfg     - calibration writes (index 0..5: a0, b1, b2, c12, c11, c22), always
//             ready; write only while no item is in flight.
// Stage one loads on the accepting edge, and a result is offered from stage six
// once the item has passed through all six stages.
// Throughput: one item per cycle unless held by result.ready; stages one and four
// hold the multiplies, the others the adds, and every stage carries its own valid bit.
// Stall: each stage advances when it is empty or the stage after it moves, so
// bubbles close up and sample.ready only falls once all six stages are full
// while result.ready is low. Nothing is dropped or repeated.
// Reset: all stages empty and all coefficients zero.
module pressure_sensor_compensation (
	input  logic          clk,
	input  logic          arst_n,
	psc_sample_if.sink    sample,
	psc_result_if.source  result,
	psc_cfg_if.sink       cfg
);

	localparam int CntW = psc_pkg::CountW;

	psc_pkg::coefs_t coefs;

	psc_coef_regs u_coef_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.coefs  (coefs)
	);

	// stage valid bits and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	assign en_s6 = !v_s6 || result.ready;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign sample.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= sample.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: extract counts, form c11*P, c12*T, c22*T
	logic [CntW-1:0]      p_in, t_in;
	logic signed [CntW:0] p_sx, t_sx;
	logic [CntW-1:0]      p_s1, t_s1;
	logic signed [26:0]   c11p_s1, c12t_s1, c22t_s1;

	assign p_in = sample.pressure_raw[psc_pkg::RawWidth-1:psc_pkg::RawShift];
	assign t_in = sample.temperature_raw[psc_pkg::RawWidth-1:psc_pkg::RawShift];
	assign p_sx = $signed({1'b0, p_in});
	assign t_sx = $signed({1'b0, t_in});

	always_ff @(posedge clk) begin
		if (en_s1) begin
			p_s1    <= p_in;
			t_s1    <= t_in;
			c11p_s1 <= coefs.c11 * p_sx;
			c12t_s1 <= coefs.c12 * t_sx;
			c22t_s1 <= coefs.c22 * t_sx;
		end
	end

	// Stage 2: a11 = b1 + floor(c11*P / 2^14); a2 from b2 and c22*T
	logic signed [16:0] a11_d;
	logic signed [31:0] a2_sum;
	logic signed [16:0] a11_s2;
	logic signed [15:0] a2_s2;
	logic signed [26:0] c12t_s2;
	logic [CntW-1:0]    p_s2, t_s2;

	assign a11_d  = 17'(coefs.b1) + 17'(c11p_s1 >>> 14);
	assign a2_sum = (32'(coefs.b2) <<< 15) + 32'(c22t_s1 >>> 1);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			a11_s2  <= a11_d;
			a2_s2   <= 16'(a2_sum >>> 16);
			c12t_s2 <= c12t_s1;
			p_s2    <= p_s1;
			t_s2    <= t_s1;
		end
	end

	// Stage 3: a1 = a11 + floor(c12*T / 2^11)
	logic signed [16:0] a1_s3;
	logic signed [15:0] a2_s3;
	logic [CntW-1:0]    p_s3, t_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			a1_s3 <= a11_s2 + 17'(c12t_s2 >>> 11);
			a2_s3 <= a2_s2;
			p_s3  <= p_s2;
			t_s3  <= t_s2;
		end
	end

	// Stage 4: a1*P and a2*T
	logic signed [27:0] a1p_s4;
	logic signed [26:0] a2t_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			a1p_s4 <= a1_s3 * $signed({1'b0, p_s3});
			a2t_s4 <= a2_s3 * $signed({1'b0, t_s3});
		end
	end

	// Stage 5: y1 = a0 + floor(a1*P / 2^10)
	logic signed [17:0] y1_s5;
	logic signed [26:0] a2t_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			y1_s5  <= 18'(coefs.a0) + 18'(a1p_s4 >>> 10);
			a2t_s5 <= a2t_s4;
		end
	end

	// Stage 6: acc = y1*2^10 + a2*T, divide by 2^13 rounding toward zero
	logic signed [27:0]               acc;
	logic signed [psc_pkg::CompW-1:0] quo_floor;
	logic                             round_up;
	logic signed [psc_pkg::CompW-1:0] comp_s6;

	assign acc       = (28'(y1_s5) <<< 10) + 28'(a2t_s5);
	assign quo_floor = acc[psc_pkg::DivShift +: psc_pkg::CompW];
	// a negative value with a remainder floors one too low
	assign round_up  = acc[27] && (acc[psc_pkg::DivShift-1:0] != '0);

	always_ff @(posedge clk) begin
		if (en_s6) begin
			comp_s6 <= quo_floor + psc_pkg::CompW'(round_up);
		end
	end

	assign result.valid         = v_s6;
	assign result.pressure_comp = comp_s6;

endmodule

>>> src/psc_coef_regs.sv
// Calibration coefficient register file, written through the config channel.
// Depends on psc_pkg and psc_cfg_if.
module psc_coef_regs (
	input  logic            clk,
	input  logic            arst_n,
	psc_cfg_if.sink         cfg,
	output psc_pkg::coefs_t coefs
);

	psc_pkg::coefs_t coefs_q;

	assign cfg.ready = 1'b1;
	assign coefs     = coefs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				psc_pkg::REG_A0: begin
					coefs_q.a0 <= cfg.data;
				end
				psc_pkg::REG_B1: begin
					coefs_q.b1 <= cfg.data;
				end
				psc_pkg::REG_B2: begin
					coefs_q.b2 <= cfg.data;
				end
				psc_pkg::REG_C12: begin
					coefs_q.c12 <= cfg.data;
				end
				psc_pkg::REG_C11: begin
					coefs_q.c11 <= cfg.data;
				end
				psc_pkg::REG_C22: begin
					coefs_q.c22 <= cfg.data;
				end
				default: begin
					// drop writes past the last register
				end
			endcase
		end
	end

endmodule

>>> verif/tb_top.sv
// Self-checking bench for pressure_sensor_compensation: drives reading pairs and calibration
// writes, predicts each compensated count in fixed point, checks results in order.
// Depends on psc_pkg, psc_ifs and the block itself.
module tb_top;

	localparam int                CycleLimit   = 200000;
	localparam int                PhaseItems   = 80;
	localparam int                RandomPhases = 8;
	localparam int                NumDirected  = 23;
	localparam psc_pkg::coef_t    CoefMax      = 16'sh7FFF;
	localparam psc_pkg::coef_t    CoefMin      = 16'sh8000;
	localparam psc_pkg::cfg_idx_t IdxSpareLo   = 3'd6;
	localparam psc_pkg::cfg_idx_t IdxSpareHi   = 3'd7;

	typedef logic signed [psc_pkg::CompW-1:0] comp_t;

	typedef struct packed {
		logic [2:0]                   setting;
		logic [psc_pkg::RawWidth-1:0] praw;
		logic [psc_pkg::RawWidth-1:0] traw;
		logic                         known;
		comp_t                        want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	psc_sample_if sample_ch();
	psc_result_if result_ch();
	psc_cfg_if    cfg_ch();

	pressure_sensor_compensation i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// calibration sets used by the directed table
	psc_pkg::coefs_t coef_sets [8] = '{
		'{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
		'{16'sh2000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
		'{CoefMin,   16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
		'{CoefMax,   CoefMax,   CoefMax,   CoefMax,   CoefMax,   CoefMax},
		'{CoefMin,   CoefMin,   CoefMin,   CoefMin,   CoefMin,   CoefMin},
		'{16'sh3ECE, 16'shB3F9, 16'shC517, 16'sh33C8, 16'sh0F2A, 16'shF6B1},
		'{CoefMin,   CoefMax,   CoefMin,   CoefMin,   CoefMin,   CoefMax},
		'{CoefMax,   CoefMin,   CoefMax,   CoefMax,   CoefMax,   CoefMin}
	};

	// setting, pressure raw, temperature raw, typed-in flag, typed-in count
	stim_row_t dir_rows [NumDirected] = '{
		// coefficients straight out of reset: everything collapses to zero
		'{3'd0, 16'h0000, 16'h0000, 1'b1, 15'sd0},
		'{3'd0, 16'hFFFF, 16'hFFFF, 1'b1, 15'sd0},
		'{3'd0, 16'h003F, 16'hFFC0, 1'b1, 15'sd0},
		// offset only: a0 / 8 whatever the readings
		'{3'd1, 16'hFFFF, 16'h0000, 1'b1, 15'sd1024},
		'{3'd1, 16'h1234, 16'hABCD, 1'b1, 15'sd1024},
		'{3'd2, 16'h0000, 16'hFFFF, 1'b1, -15'sd4096},
		'{3'd2, 16'hFFC0, 16'h003F, 1'b1, -15'sd4096},
		'{3'd3, 16'h0000, 16'h0000, 1'b0, 15'sd0},
		'{3'd3, 16'hFFFF, 16'hFFFF, 1'b0, 15'sd0},
		'{3'd3, 16'hFFC0, 16'h0000, 1'b0, 15'sd0},
		'{3'd3, 16'h0000, 16'hFFC0, 1'b0, 15'sd0},
		'{3'd4, 16'h0000, 16'h0000, 1'b0, 15'sd0},
		'{3'd4, 16'hFFFF, 16'hFFFF, 1'b0, 15'sd0},
		'{3'd4, 16'hFFC0, 16'h0000, 1'b0, 15'sd0},
		'{3'd4, 16'h0000, 16'hFFC0, 1'b0, 15'sd0},
		'{3'd5, 16'h6680, 16'h7E40, 1'b0, 15'sd0},
		'{3'd5, 16'h66BF, 16'h7E7F, 1'b0, 15'sd0},
		'{3'd5, 16'h8000, 16'h8000, 1'b0, 15'sd0},
		'{3'd5, 16'h5555, 16'hAAAA, 1'b0, 15'sd0},
		'{3'd6, 16'hFFFF, 16'hFFFF, 1'b0, 15'sd0},
		'{3'd6, 16'hFFFF, 16'h0000, 1'b0, 15'sd0},
		'{3'd7, 16'hFFFF, 16'hFFFF, 1'b0, 15'sd0},
		'{3'd7, 16'h0000, 16'hFFFF, 1'b0, 15'sd0}
	};

	psc_pkg::coefs_t coefs_now;
	comp_t           pending_comp [$];
	logic            cur_known;
	comp_t           cur_want;
	int              gap_odds;
	int              stall_left;
	int              cycle_count;
	int              fail_count;
	int              samples_in;
	int              results_seen;
	int              coef_writes;
	int              settings_used;

	always #5 clk = ~clk;

	// Fixed-point compensation polynomial; every shift of a signed term is a floor.
	function automatic comp_t compensate(psc_pkg::coefs_t k,
			logic [psc_pkg::RawWidth-1:0] praw, logic [psc_pkg::RawWidth-1:0] traw);
		longint p;
		longint t;
		longint a11;
		longint a1;
		longint a2;
		longint y1;
		longint acc;
		p = praw >> psc_pkg::RawShift;
		t = traw >> psc_pkg::RawShift;
		a11 = ((longint'(k.b1) <<< 14) + longint'(k.c11) * p) >>> 14;
		a1  = ((a11 <<< 11) + longint'(k.c12) * t) >>> 11;
		a2  = ((longint'(k.b2) <<< 15) + ((longint'(k.c22) * t) >>> 1)) >>> 16;
		y1  = ((longint'(k.a0) <<< 10) + a1 * p) >>> 10;
		acc = (y1 <<< 10) + a2 * t;
		// signed division truncates toward zero
		return comp_t'(acc / (64'sd1 <<< psc_pkg::DivShift));
	endfunction

	function automatic int gap_len();
		if (gap_odds == 0 || $urandom_range(1, gap_odds) != 1)
			return 0;
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [psc_pkg::RawWidth-1:0] rand_raw();
		case ($urandom_range(0, 7))
			0: rand_raw = {10'h3FF, 6'($urandom)};
			1: rand_raw = {10'h000, 6'($urandom)};
			default: rand_raw = psc_pkg::RawWidth'($urandom);
		endcase
	endfunction

	function automatic psc_pkg::coef_t rand_coef();
		case ($urandom_range(0, 9))
			0: rand_coef = CoefMax;
			1: rand_coef = CoefMin;
			2: rand_coef = '0;
			3: rand_coef = psc_pkg::coef_t'($urandom_range(0, 511)) - 16'sd256;
			default: rand_coef = psc_pkg::coef_t'($urandom);
		endcase
	endfunction

	// All tasks below start and end at a falling edge.
	task automatic send_sample(logic [psc_pkg::RawWidth-1:0] praw,
			logic [psc_pkg::RawWidth-1:0] traw, logic known, comp_t want);
		int n;
		n = gap_len();
		if (n != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		sample_ch.valid           <= 1'b1;
		sample_ch.pressure_raw    <= praw;
		sample_ch.temperature_raw <= traw;
		cur_known = known;
		cur_want  = want;
		do @(posedge clk); while (!sample_ch.ready);
		@(negedge clk);
	endtask

	task automatic write_coef(psc_pkg::cfg_idx_t idx, logic [psc_pkg::CoefW-1:0] val);
		int n;
		n = gap_len();
		if (n != 0) begin
			cfg_ch.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			psc_pkg::REG_A0:  coefs_now.a0  = val;
			psc_pkg::REG_B1:  coefs_now.b1  = val;
			psc_pkg::REG_B2:  coefs_now.b2  = val;
			psc_pkg::REG_C12: coefs_now.c12 = val;
			psc_pkg::REG_C11: coefs_now.c11 = val;
			psc_pkg::REG_C22: coefs_now.c22 = val;
			default: ; // unused index, dropped by the block
		endcase
		coef_writes++;
		@(negedge clk);
	endtask

	// Stop sending and wait until every item in flight has come out.
	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (pending_comp.size() != 0) @(negedge clk);
	endtask

	task automatic load_coefs(psc_pkg::coefs_t k);
		write_coef(psc_pkg::REG_A0,  k.a0);
		write_coef(psc_pkg::REG_B1,  k.b1);
		write_coef(psc_pkg::REG_B2,  k.b2);
		write_coef(psc_pkg::REG_C12, k.c12);
		write_coef(psc_pkg::REG_C11, k.c11);
		write_coef(psc_pkg::REG_C22, k.c22);
		// out-of-range index must not disturb any coefficient
		write_coef($urandom_range(0, 1) ? IdxSpareHi : IdxSpareLo,
			psc_pkg::CoefW'($urandom));
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	// Sink side: random bursts of low ready.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else begin
			stall_left = gap_len();
			if (stall_left != 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Record accepted samples and check results in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready) begin
				pending_comp.push_back(cur_known ? cur_want :
					compensate(coefs_now, sample_ch.pressure_raw, sample_ch.temperature_raw));
				samples_in++;
			end
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (pending_comp.size() == 0) begin
					fail_count++;
					$display("%0t: pressure_comp expected none, got %0d", $time,
						result_ch.pressure_comp);
				end else if (result_ch.pressure_comp !== pending_comp[0]) begin
					fail_count++;
					$display("%0t: pressure_comp expected %0d, got %0d", $time,
						pending_comp[0], result_ch.pressure_comp);
					void'(pending_comp.pop_front());
				end else begin
					void'(pending_comp.pop_front());
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("%0t: timeout, %0d results outstanding", $time, pending_comp.size());
			$display("FAIL pressure_sensor_compensation");
			$finish;
		end
	end

	initial begin
		logic [2:0]      cur_set;
		psc_pkg::coefs_t k;
		clk                       = 1'b0;
		arst_n                    = 1'b0;
		sample_ch.valid           = 1'b0;
		sample_ch.pressure_raw    = '0;
		sample_ch.temperature_raw = '0;
		result_ch.ready           = 1'b0;
		cfg_ch.valid              = 1'b0;
		cfg_ch.index              = psc_pkg::REG_A0;
		cfg_ch.data               = '0;
		coefs_now                 = '0;
		cur_known                 = 1'b0;
		cur_want                  = '0;
		gap_odds                  = 4;
		stall_left                = 0;
		cycle_count               = 0;
		fail_count                = 0;
		samples_in                = 0;
		results_seen              = 0;
		coef_writes               = 0;
		settings_used             = 1;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table; the first rows run on the reset coefficients
		cur_set = 3'd0;
		for (int i = 0; i < NumDirected; i++) begin
			if (dir_rows[i].setting != cur_set) begin
				drain();
				load_coefs(coef_sets[dir_rows[i].setting]);
				cur_set = dir_rows[i].setting;
			end
			send_sample(dir_rows[i].praw, dir_rows[i].traw, dir_rows[i].known,
				dir_rows[i].want);
		end

		// random phases, each on a fresh calibration; phases 1, 4 and the last run without idling
		for (int ph = 0; ph < RandomPhases; ph++) begin
			drain();
			if (ph == 0)
				k = '{CoefMax, CoefMax, CoefMax, CoefMax, CoefMax, CoefMax};
			else if (ph == 1)
				k = '{CoefMin, CoefMin, CoefMin, CoefMin, CoefMin, CoefMin};
			else
				k = '{rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
					rand_coef()};
			gap_odds = (ph == RandomPhases - 1 || ph % 3 == 1) ? 0 : $urandom_range(2, 6);
			load_coefs(k);
			for (int n = 0; n < PhaseItems; n++)
				send_sample(rand_raw(), rand_raw(), 1'b0, '0);
		end

		drain();
		repeat (12) @(posedge clk);
		$display("Covered %0d reading pairs over %0d calibration settings (%0d register writes),",
			samples_in, settings_used, coef_writes);
		$display("%0d compensated counts checked, %0d mismatches.", results_seen, fail_count);
		if (fail_count == 0 && pending_comp.size() == 0)
			$display("PASS pressure_sensor_compensation");
		else
			$display("FAIL pressure_sensor_compensation");
		$finish;
	end

endmodule

>>> filelist.f
src/psc_pkg.sv
src/psc_ifs.sv
src/psc_coef_regs.sv
src/pressure_sensor_compensation.sv
verif/tb_top.sv
